[rtl/core/fmn_pkg.sv]
package fmn_pkg;

    // frame geometry limits
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);

    // field widths
    localparam int DIM_W   = 9;
    localparam int COORD_W = 8;
    localparam int VAL_W   = 16;
    localparam int BYTE_W  = 8;
    localparam int PROD_W  = COORD_W + DIM_W + 1;

    // 1.0 in unsigned q4.12, stands in for a zero peak or span
    localparam logic [VAL_W-1:0] ONE_UNIT = VAL_W'(4096);

    // operation codes carried in s_tuser
    typedef enum logic [2:0] {
        MODE_WR_COLOR = 3'd0,
        MODE_WR_DEPTH = 3'd1,
        MODE_READ     = 3'd2,
        MODE_SCAN     = 3'd3,
        MODE_EXPORT   = 3'd4
    } mode_t;

    // configuration register indexes
    typedef enum logic {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR,
        ST_EXEC,
        ST_READ,
        ST_SCAN,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [VAL_W-1:0] blue;
        logic [VAL_W-1:0] green;
        logic [VAL_W-1:0] red;
    } color_t;

    // one access to the pixel store: read always, write when enabled
    typedef struct packed {
        logic              wr_color;
        logic              wr_depth;
        logic [ADDR_W-1:0] addr;
        color_t            color;
        logic [VAL_W-1:0]  depth;
    } store_cmd_t;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] num;
        logic [VAL_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [BYTE_W-1:0] quot;
    } div_rsp_t;

endpackage

[rtl/core/fmn_store.sv]
module fmn_store (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  fmn_pkg::store_cmd_t      cmd,
    output logic                     ready,
    output fmn_pkg::color_t          rd_color,
    output logic [fmn_pkg::VAL_W-1:0] rd_depth
);
    import fmn_pkg::*;

    color_t           color_mem [STORE_DEPTH];
    logic [VAL_W-1:0] depth_mem [STORE_DEPTH];

    logic              clearing_reg;
    logic [ADDR_W-1:0] clear_addr_reg;
    color_t            rd_color_reg;
    logic [VAL_W-1:0]  rd_depth_reg;

    logic              we_color;
    logic              we_depth;
    logic [ADDR_W-1:0] mem_addr;
    color_t            wr_color_data;
    logic [VAL_W-1:0]  wr_depth_data;

    // clearing pass after reset, one entry a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
        end else if (clearing_reg) begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == ADDR_W'(STORE_DEPTH - 1)) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // port selection between clearing pass and normal access
    always_comb begin
        if (clearing_reg) begin
            we_color      = 1'b1;
            we_depth      = 1'b1;
            mem_addr      = clear_addr_reg;
            wr_color_data = '0;
            wr_depth_data = '0;
        end else begin
            we_color      = cmd.wr_color;
            we_depth      = cmd.wr_depth;
            mem_addr      = cmd.addr;
            wr_color_data = cmd.color;
            wr_depth_data = cmd.depth;
        end
    end

    // color plane
    always_ff @(posedge aclk) begin
        if (we_color) begin
            color_mem[mem_addr] <= wr_color_data;
        end
        rd_color_reg <= color_mem[mem_addr];
    end

    // depth plane
    always_ff @(posedge aclk) begin
        if (we_depth) begin
            depth_mem[mem_addr] <= wr_depth_data;
        end
        rd_depth_reg <= depth_mem[mem_addr];
    end

    assign ready    = !clearing_reg;
    assign rd_color = rd_color_reg;
    assign rd_depth = rd_depth_reg;

endmodule

[rtl/core/fmn_div.sv]
module fmn_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  fmn_pkg::div_req_t req,
    output fmn_pkg::div_rsp_t rsp
);
    import fmn_pkg::*;

    localparam int WIDE_W = VAL_W + BYTE_W;
    localparam int STEP_W = $clog2(BYTE_W);

    logic [WIDE_W-1:0] rem_reg;
    logic [WIDE_W-1:0] dsh_reg;
    logic [BYTE_W-1:0] quot_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              sat_reg;
    logic              done_reg;

    logic [WIDE_W-1:0] scaled;
    logic [WIDE_W-1:0] limit;
    logic              fits;

    // num * 255 as a shift and subtract; quotient saturates past 255
    assign scaled = {req.num, {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, req.num};
    assign limit  = {req.den, {BYTE_W{1'b0}}};
    assign fits   = (rem_reg >= dsh_reg);

    // restoring division, one quotient bit a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(BYTE_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg  <= scaled;
            dsh_reg  <= {1'b0, req.den, {(BYTE_W - 1){1'b0}}};
            sat_reg  <= (scaled >= limit);
            quot_reg <= '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quot_reg <= {quot_reg[BYTE_W-2:0], fits};
            dsh_reg  <= dsh_reg >> 1;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = sat_reg ? {BYTE_W{1'b1}} : quot_reg;

endmodule

[rtl/core/framebuffer_minmax_normalizer.sv]
// sequence: write and out-of-frame items pass the address, execute and done states; a read
// adds a store read, an export a store read and four divisions on the one shared divider,
// and a scan makes one store read per pixel of the frame_width * frame_height frame.
// one item at a time; the next item is taken once the result sits in the output register.
// reset: synchronous active-low; afterwards a clearing pass zeroes all 65536 store entries,
// during which no item is taken (configuration writes are taken).
module framebuffer_minmax_normalizer (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [fmn_pkg::DIM_W-1:0]   cfg_wdata,
    // input channel
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [79:0]                 s_tdata,  // col, row, red_in, green_in, blue_in, depth_in
    input  logic [2:0]                  s_tuser,  // mode
    // result channel
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [95:0]                 m_tdata,  // red_out, green_out, blue_out, depth_out,
                                                  // red_byte, green_byte, blue_byte, depth_byte
    output logic                        m_tuser   // status
);
    import fmn_pkg::*;

    localparam int LANES = 4;

    state_t state_reg, state_next;

    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [DIM_W-1:0]   cfg_clamped;

    mode_t              mode_reg;
    logic [COORD_W-1:0] col_reg;
    logic [COORD_W-1:0] row_reg;
    color_t             color_in_reg;
    logic [VAL_W-1:0]   depth_in_reg;

    logic [ADDR_W-1:0]  addr_reg;
    logic               inside_reg;
    logic [COUNT_W-1:0] scan_total_reg;

    logic [COUNT_W-1:0] scan_cnt_reg;
    logic               scan_vld_reg;
    logic [VAL_W-1:0]   peak_acc_reg;
    logic [VAL_W-1:0]   low_acc_reg;
    logic [VAL_W-1:0]   high_acc_reg;

    logic [VAL_W-1:0]   color_peak_reg;
    logic [VAL_W-1:0]   depth_low_reg;
    logic [VAL_W-1:0]   depth_high_reg;

    logic                         res_status_reg;
    color_t                       res_color_reg;
    logic [VAL_W-1:0]             res_depth_reg;
    logic [LANES-1:0][BYTE_W-1:0] res_bytes_reg;
    logic [1:0]                   lane_reg;

    logic        m_tvalid_reg;
    logic        m_tuser_reg;
    logic [95:0] m_tdata_reg;

    store_cmd_t       store_cmd;
    logic             store_ready;
    color_t           rd_color;
    logic [VAL_W-1:0] rd_depth;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    logic [PROD_W-1:0] lin_addr;
    logic [PROD_W-1:0] frame_area;
    logic              in_frame;
    logic              scan_issue;
    logic              scan_done;
    logic              out_load;
    logic [VAL_W-1:0]  max_rg;
    logic [VAL_W-1:0]  max_bp;
    logic [VAL_W-1:0]  peak_eff;
    logic [VAL_W-1:0]  span_eff;
    logic [VAL_W-1:0]  depth_off;

    fmn_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (store_cmd),
        .ready    (store_ready),
        .rd_color (rd_color),
        .rd_depth (rd_depth)
    );

    fmn_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // configuration writes, clamped to the legal frame size
    always_comb begin
        cfg_clamped = cfg_wdata;
        if (cfg_wdata == '0) begin
            cfg_clamped = DIM_W'(1);
        end else if (cfg_index == CFG_FRAME_WIDTH && cfg_wdata > DIM_W'(MAX_WIDTH)) begin
            cfg_clamped = DIM_W'(MAX_WIDTH);
        end else if (cfg_index == CFG_FRAME_HEIGHT && cfg_wdata > DIM_W'(MAX_HEIGHT)) begin
            cfg_clamped = DIM_W'(MAX_HEIGHT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_W'(MAX_WIDTH);
            height_reg <= DIM_W'(MAX_HEIGHT);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  width_reg  <= cfg_clamped;
                CFG_FRAME_HEIGHT: height_reg <= cfg_clamped;
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    // address and frame checks
    assign lin_addr   = PROD_W'(row_reg) * PROD_W'(width_reg) + PROD_W'(col_reg);
    assign frame_area = PROD_W'(width_reg) * PROD_W'(height_reg);
    assign in_frame   = ({1'b0, col_reg} < width_reg) && ({1'b0, row_reg} < height_reg)
                        && (lin_addr < PROD_W'(STORE_DEPTH));

    // scan walk
    assign scan_issue = (scan_cnt_reg < scan_total_reg);
    assign scan_done  = !scan_issue && !scan_vld_reg;
    assign max_rg     = (rd_color.red > rd_color.green) ? rd_color.red : rd_color.green;
    assign max_bp     = (rd_color.blue > peak_acc_reg) ? rd_color.blue : peak_acc_reg;

    // divider operands
    assign peak_eff  = (color_peak_reg != '0) ? color_peak_reg : ONE_UNIT;
    assign span_eff  = (depth_high_reg > depth_low_reg) ? (depth_high_reg - depth_low_reg)
                                                         : ONE_UNIT;
    assign depth_off = (res_depth_reg > depth_low_reg) ? (res_depth_reg - depth_low_reg)
                                                        : '0;

    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && store_ready) state_next = ST_ADDR;
            end
            ST_ADDR: state_next = ST_EXEC;
            ST_EXEC: begin
                unique case (mode_reg)
                    MODE_SCAN:                  state_next = ST_SCAN;
                    MODE_READ, MODE_EXPORT:     state_next = inside_reg ? ST_READ : ST_DONE;
                    default:                    state_next = ST_DONE;
                endcase
            end
            ST_READ: state_next = (mode_reg == MODE_EXPORT) ? ST_DIV_START : ST_DONE;
            ST_SCAN: begin
                if (scan_done) state_next = ST_DONE;
            end
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    state_next = (lane_reg == 2'(LANES - 1)) ? ST_DONE : ST_DIV_START;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready        = 1'b0;
        store_cmd       = '0;
        store_cmd.addr  = addr_reg;
        store_cmd.color = color_in_reg;
        store_cmd.depth = depth_in_reg;
        div_req.start   = 1'b0;
        div_req.num     = depth_off;
        div_req.den     = span_eff;
        unique case (lane_reg)
            2'd0:    div_req.num = res_color_reg.red;
            2'd1:    div_req.num = res_color_reg.green;
            2'd2:    div_req.num = res_color_reg.blue;
            default: div_req.num = depth_off;
        endcase
        if (lane_reg != 2'(LANES - 1)) begin
            div_req.den = peak_eff;
        end
        unique case (state_reg)
            ST_IDLE: s_tready = store_ready;
            ST_EXEC: begin
                store_cmd.wr_color = inside_reg && (mode_reg == MODE_WR_COLOR);
                store_cmd.wr_depth = inside_reg && (mode_reg == MODE_WR_DEPTH);
            end
            ST_SCAN:      store_cmd.addr = scan_cnt_reg[ADDR_W-1:0];
            ST_DIV_START: div_req.start  = 1'b1;
            default:      s_tready       = 1'b0;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // input capture and address calculation
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mode_reg           <= mode_t'(s_tuser);
            col_reg            <= s_tdata[7:0];
            row_reg            <= s_tdata[15:8];
            color_in_reg.red   <= s_tdata[31:16];
            color_in_reg.green <= s_tdata[47:32];
            color_in_reg.blue  <= s_tdata[63:48];
            depth_in_reg       <= s_tdata[79:64];
        end
        if (state_reg == ST_ADDR) begin
            addr_reg   <= lin_addr[ADDR_W-1:0];
            inside_reg <= in_frame;
            scan_total_reg <= (frame_area > PROD_W'(STORE_DEPTH)) ? COUNT_W'(STORE_DEPTH)
                                                                  : frame_area[COUNT_W-1:0];
        end
    end

    // result assembly
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            res_status_reg <= 1'b0;
            res_color_reg  <= '0;
            res_depth_reg  <= '0;
            res_bytes_reg  <= '0;
        end
        if (state_reg == ST_EXEC) begin
            res_status_reg <= !inside_reg && (mode_reg == MODE_WR_COLOR
                              || mode_reg == MODE_WR_DEPTH || mode_reg == MODE_READ
                              || mode_reg == MODE_EXPORT);
        end
        if (state_reg == ST_READ) begin
            res_color_reg <= rd_color;
            res_depth_reg <= rd_depth;
            lane_reg      <= '0;
        end
        if (state_reg == ST_DIV_WAIT && div_rsp.done) begin
            res_bytes_reg[lane_reg] <= div_rsp.quot;
            lane_reg                <= lane_reg + 1'b1;
        end
    end

    // scan accumulators
    always_ff @(posedge aclk) begin
        if (state_reg == ST_EXEC) begin
            scan_cnt_reg <= '0;
            peak_acc_reg <= '0;
            low_acc_reg  <= {VAL_W{1'b1}};
            high_acc_reg <= '0;
        end else if (state_reg == ST_SCAN) begin
            if (scan_issue) begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            if (scan_vld_reg) begin
                peak_acc_reg <= (max_rg > max_bp) ? max_rg : max_bp;
                if (rd_depth > high_acc_reg) high_acc_reg <= rd_depth;
                if (rd_depth < low_acc_reg)  low_acc_reg  <= rd_depth;
            end
        end
    end

    // read-data valid flag and committed extremes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_vld_reg   <= 1'b0;
            color_peak_reg <= '0;
            depth_low_reg  <= {VAL_W{1'b1}};
            depth_high_reg <= '0;
        end else begin
            scan_vld_reg <= (state_reg == ST_SCAN) && scan_issue;
            if (state_reg == ST_SCAN && scan_done) begin
                color_peak_reg <= peak_acc_reg;
                depth_low_reg  <= low_acc_reg;
                depth_high_reg <= high_acc_reg;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tuser_reg <= res_status_reg;
            m_tdata_reg <= {res_bytes_reg, res_depth_reg, res_color_reg.blue,
                            res_color_reg.green, res_color_reg.red};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    // one item at a time: no new transfer right after one is taken
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken twice in a row");

    // the divider only finishes while the sequencer waits for it
    a_div_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider result outside its wait state");

    // a new result only comes from the done state
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done state");

    // no item is taken during the clearing pass
    a_no_take_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        !store_ready |-> !s_tready)
        else $error("input taken while store clears");

endmodule
